### hw/rtl/mma_pkg.sv
package mma_pkg;

  localparam int NUM_CHANNELS = 6;
  localparam int MAX_WINDOW   = 64;
  localparam int CH_W         = 3;
  localparam int SAMPLE_W     = 8;
  localparam int WIN_W        = 7;
  localparam int POS_W        = $clog2(MAX_WINDOW);
  localparam int SUM_W        = 15;
  localparam int MAG_W        = SUM_W - 1;
  localparam int STEP_W       = $clog2(MAG_W);
  localparam int RING_DEPTH   = NUM_CHANNELS * MAX_WINDOW;
  localparam int ADDR_W       = $clog2(RING_DEPTH);
  localparam int CFG_IDX_W    = 3;
  localparam int AVG_MAX      = 127;
  localparam int AVG_MIN_MAG  = 128;

  localparam logic [WIN_W-1:0] WIN_RESET [NUM_CHANNELS] = '{
    7'd3, 7'd3, 7'd5, 7'd5, 7'd15, 7'd8
  };

  typedef struct packed {
    logic             start;
    logic [MAG_W-1:0] dividend;
    logic [WIN_W-1:0] divisor;
    logic             neg;
  } div_req_t;

  typedef struct packed {
    logic                       done;
    logic [WIN_W-1:0]           rem;
    logic signed [SAMPLE_W-1:0] avg;
  } div_resp_t;

endpackage

### hw/rtl/multichannel_moving_average.sv
// Six-channel moving average. Each input transaction names a channel and a signed sample, and
// produces one output transaction with that channel's running sum divided by its fill count,
// truncated toward zero and saturated to 8 bits; an out-of-range channel returns zero and
// leaves all state alone. One shared restoring divider, one quotient bit per cycle, sets the
// rate unless out_ready holds a finished result back; a transaction whose write position
// runs past a shrunken window also sends that position through a modulo on the same divider.
// A result may wait in the output register while the next transaction is accepted.
// The sample ring is a single-port-write memory with no clearing pass after reset: a
// per-channel high-water mark makes never-written entries read as zero.
module multichannel_moving_average (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic        [mma_pkg::CH_W-1:0]        in_channel,
  input  logic signed [mma_pkg::SAMPLE_W-1:0]    in_sample,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [mma_pkg::SAMPLE_W-1:0]    out_average,
  input  logic                                   cfg_we,
  input  logic        [mma_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic        [mma_pkg::WIN_W-1:0]       cfg_wdata
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_READ   = 6'b000010,
    ST_UPDATE = 6'b000100,
    ST_WRAP   = 6'b001000,
    ST_DIV    = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t                              state_r;
  state_t                              state_nxt;

  logic        [mma_pkg::WIN_W-1:0]    win_r  [mma_pkg::NUM_CHANNELS];
  logic        [mma_pkg::POS_W-1:0]    pos_r  [mma_pkg::NUM_CHANNELS];
  logic signed [mma_pkg::SUM_W-1:0]    sum_r  [mma_pkg::NUM_CHANNELS];
  logic        [mma_pkg::WIN_W-1:0]    fill_r [mma_pkg::NUM_CHANNELS];
  logic        [mma_pkg::WIN_W-1:0]    hw_r   [mma_pkg::NUM_CHANNELS];

  logic        [mma_pkg::CH_W-1:0]     ch_r;
  logic signed [mma_pkg::SAMPLE_W-1:0] sample_r;
  logic signed [mma_pkg::SAMPLE_W-1:0] res_r;
  logic                                out_valid_r;
  logic signed [mma_pkg::SAMPLE_W-1:0] out_average_r;

  logic                                in_acc;
  logic                                ch_ok;
  logic                                out_free;
  logic        [mma_pkg::WIN_W-1:0]    win_raw;
  logic        [mma_pkg::WIN_W-1:0]    win_eff;
  logic        [mma_pkg::POS_W-1:0]    pos_cur;
  logic        [mma_pkg::WIN_W-1:0]    pos_inc;
  logic                                wrap_needed;
  logic        [mma_pkg::POS_W-1:0]    pos_simple;
  logic                                old_ok;
  logic signed [mma_pkg::SAMPLE_W-1:0] old_s;
  logic signed [mma_pkg::SUM_W-1:0]    sum_new;
  logic        [mma_pkg::WIN_W-1:0]    fill_new;
  logic signed [mma_pkg::SUM_W-1:0]    div_sum;
  logic        [mma_pkg::SUM_W-1:0]    div_mag;
  logic        [mma_pkg::ADDR_W-1:0]   ram_addr;
  logic signed [mma_pkg::SAMPLE_W-1:0] ram_rdata;
  logic                                ram_we;

  mma_pkg::div_req_t                   div_req;
  mma_pkg::div_resp_t                  div_resp;

  assign in_acc   = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign ch_ok    = in_channel < mma_pkg::CH_W'(mma_pkg::NUM_CHANNELS);
  assign out_free = !out_valid_r || out_ready;

  assign win_raw = win_r[ch_r];
  always_comb begin
    if (win_raw == '0) begin
      win_eff = mma_pkg::WIN_W'(1);
    end else if (win_raw > mma_pkg::WIN_W'(mma_pkg::MAX_WINDOW)) begin
      win_eff = mma_pkg::WIN_W'(mma_pkg::MAX_WINDOW);
    end else begin
      win_eff = win_raw;
    end
  end

  assign pos_cur     = pos_r[ch_r];
  assign pos_inc     = {1'b0, pos_cur} + 1'b1;
  assign wrap_needed = pos_inc > win_eff;
  assign pos_simple  = (pos_inc == win_eff) ? '0 : pos_inc[mma_pkg::POS_W-1:0];
  assign old_ok      = {1'b0, pos_cur} < hw_r[ch_r];
  assign old_s       = old_ok ? ram_rdata : '0;
  assign sum_new     = sum_r[ch_r] - mma_pkg::SUM_W'(old_s) + mma_pkg::SUM_W'(sample_r);
  assign fill_new    = (fill_r[ch_r] < win_eff) ? fill_r[ch_r] + 1'b1 : fill_r[ch_r];
  assign div_sum     = (state_r == ST_UPDATE) ? sum_new : sum_r[ch_r];
  assign div_mag     = div_sum[mma_pkg::SUM_W-1] ? mma_pkg::SUM_W'(-div_sum)
                                                 : mma_pkg::SUM_W'(div_sum);
  assign ram_addr    = mma_pkg::ADDR_W'({ch_r, pos_cur});
  assign ram_we      = (state_r == ST_UPDATE);

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = div_mag[mma_pkg::MAG_W-1:0];
    div_req.divisor  = (state_r == ST_UPDATE) ? fill_new : fill_r[ch_r];
    div_req.neg      = div_sum[mma_pkg::SUM_W-1];
    if (state_r == ST_UPDATE) begin
      div_req.start = 1'b1;
      if (wrap_needed) begin
        div_req.dividend = mma_pkg::MAG_W'(pos_inc);
        div_req.divisor  = win_eff;
        div_req.neg      = 1'b0;
      end
    end else if (state_r == ST_WRAP && div_resp.done) begin
      div_req.start = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ch_ok ? ST_READ : ST_FINISH;
        end
      end
      ST_READ: begin
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_nxt = wrap_needed ? ST_WRAP : ST_DIV;
      end
      ST_WRAP: begin
        if (div_resp.done) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_resp.done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < mma_pkg::NUM_CHANNELS; i++) begin
        win_r[i]  <= mma_pkg::WIN_RESET[i];
        pos_r[i]  <= '0;
        sum_r[i]  <= '0;
        fill_r[i] <= '0;
        hw_r[i]   <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we && cfg_index < mma_pkg::CFG_IDX_W'(mma_pkg::NUM_CHANNELS)) begin
        win_r[cfg_index] <= cfg_wdata;
      end
      if (state_r == ST_UPDATE) begin
        sum_r[ch_r]  <= sum_new;
        fill_r[ch_r] <= fill_new;
        if (!old_ok) begin
          hw_r[ch_r] <= pos_inc;
        end
        if (!wrap_needed) begin
          pos_r[ch_r] <= pos_simple;
        end
      end
      if (state_r == ST_WRAP && div_resp.done) begin
        pos_r[ch_r] <= div_resp.rem[mma_pkg::POS_W-1:0];
      end
      if (state_r == ST_FINISH && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ch_r     <= in_channel;
      sample_r <= in_sample;
      res_r    <= '0;
    end else if (state_r == ST_DIV && div_resp.done) begin
      res_r <= div_resp.avg;
    end
    if (state_r == ST_FINISH && out_free) begin
      out_average_r <= res_r;
    end
  end

  mma_ring_ram u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (sample_r),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  mma_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .resp  (div_resp)
  );

  assign out_valid   = out_valid_r;
  assign out_average = out_average_r;

  a_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    div_resp.done |-> (state_r == ST_WRAP || state_r == ST_DIV))
    else $error("Divider finished while the sequencer was not waiting for it.");

  a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (fill_r[ch_r] != '0 &&
                             fill_r[ch_r] <= mma_pkg::WIN_W'(mma_pkg::MAX_WINDOW)))
    else $error("Fill count out of range during the average division.");

  a_pos_below_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> ({1'b0, pos_r[ch_r]} <= hw_r[ch_r]))
    else $error("Write position ran past the high-water mark.");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPDATE) |=> (state_r == ST_WRAP || state_r == ST_DIV))
    else $error("Sequencer left the update step without starting the divider.");

endmodule

### hw/rtl/mma_ring_ram.sv
module mma_ring_ram (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic        [mma_pkg::ADDR_W-1:0]      waddr,
  input  logic signed [mma_pkg::SAMPLE_W-1:0]    wdata,
  input  logic        [mma_pkg::ADDR_W-1:0]      raddr,
  output logic signed [mma_pkg::SAMPLE_W-1:0]    rdata
);

  logic signed [mma_pkg::SAMPLE_W-1:0] mem [mma_pkg::RING_DEPTH];
  logic signed [mma_pkg::SAMPLE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/mma_divider.sv
module mma_divider (
  input  logic                clk,
  input  logic                rst_n,
  input  mma_pkg::div_req_t   req,
  output mma_pkg::div_resp_t  resp
);

  logic                              busy_r;
  logic                              done_r;
  logic [mma_pkg::STEP_W-1:0]        cnt_r;
  logic [mma_pkg::WIN_W-1:0]         rem_r;
  logic [mma_pkg::MAG_W-1:0]         quo_r;
  logic [mma_pkg::WIN_W-1:0]         dvs_r;
  logic                              neg_r;

  logic [mma_pkg::WIN_W:0]           trial;
  logic [mma_pkg::WIN_W:0]           diff;
  logic                              fits;
  logic [mma_pkg::WIN_W-1:0]         rem_nxt;
  logic [mma_pkg::MAG_W-1:0]         neg_q;

  assign trial   = {rem_r, quo_r[mma_pkg::MAG_W-1]};
  assign fits    = trial >= {1'b0, dvs_r};
  assign diff    = trial - {1'b0, dvs_r};
  assign rem_nxt = fits ? diff[mma_pkg::WIN_W-1:0] : trial[mma_pkg::WIN_W-1:0];
  assign neg_q   = mma_pkg::MAG_W'(0) - quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == mma_pkg::STEP_W'(mma_pkg::MAG_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      dvs_r <= req.divisor;
      neg_r <= req.neg;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[mma_pkg::MAG_W-2:0], fits};
    end
  end

  always_comb begin
    resp.done = done_r;
    resp.rem  = rem_r;
    if (neg_r) begin
      if (quo_r > mma_pkg::MAG_W'(mma_pkg::AVG_MIN_MAG)) begin
        resp.avg = -8'sd128;
      end else begin
        resp.avg = neg_q[mma_pkg::SAMPLE_W-1:0];
      end
    end else begin
      if (quo_r > mma_pkg::MAG_W'(mma_pkg::AVG_MAX)) begin
        resp.avg = 8'sd127;
      end else begin
        resp.avg = quo_r[mma_pkg::SAMPLE_W-1:0];
      end
    end
  end

endmodule

### dv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 40;
  localparam int REPORT_MAX  = 10;

  logic                                clk         = 1'b0;
  logic                                rst_n       = 1'b0;
  logic                                in_valid    = 1'b0;
  logic                                in_ready;
  logic        [mma_pkg::CH_W-1:0]     in_channel  = '0;
  logic signed [mma_pkg::SAMPLE_W-1:0] in_sample   = '0;
  logic                                out_valid;
  logic                                out_ready   = 1'b0;
  logic signed [mma_pkg::SAMPLE_W-1:0] out_average;
  logic                                cfg_we      = 1'b0;
  logic        [mma_pkg::CFG_IDX_W-1:0] cfg_index  = '0;
  logic        [mma_pkg::WIN_W-1:0]    cfg_wdata   = '0;

  logic        [mma_pkg::WIN_W-1:0]    win_cfg  [mma_pkg::NUM_CHANNELS] = mma_pkg::WIN_RESET;
  logic signed [mma_pkg::SAMPLE_W-1:0] ring_mem [mma_pkg::NUM_CHANNELS][mma_pkg::MAX_WINDOW] =
    '{default: '0};
  int                                  wr_pos   [mma_pkg::NUM_CHANNELS] = '{default: 0};
  int                                  run_sum  [mma_pkg::NUM_CHANNELS] = '{default: 0};
  int                                  fill_cnt [mma_pkg::NUM_CHANNELS] = '{default: 0};

  logic signed [mma_pkg::SAMPLE_W-1:0] expected_averages [$];
  int                                  err_cnt     = 0;
  int                                  idle_cycles = 0;
  int                                  rx_left     = 0;
  int                                  burst_left  = 0;
  bit                                  gaps_on     = 1'b1;

  multichannel_moving_average dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_channel  (in_channel),
    .in_sample   (in_sample),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_average (out_average),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void log_failure(input string msg);
    err_cnt++;
    if (err_cnt <= REPORT_MAX) begin
      $display("%s", msg);
    end
  endfunction

  function automatic logic signed [mma_pkg::SAMPLE_W-1:0] predict_average(
    input logic        [mma_pkg::CH_W-1:0]     ch,
    input logic signed [mma_pkg::SAMPLE_W-1:0] smp
  );
    int win;
    int pos;
    int avg;
    if (ch >= mma_pkg::NUM_CHANNELS) begin
      return '0;
    end
    win = win_cfg[ch];
    if (win == 0) begin
      win = 1;
    end
    if (win > mma_pkg::MAX_WINDOW) begin
      win = mma_pkg::MAX_WINDOW;
    end
    pos = wr_pos[ch] % mma_pkg::MAX_WINDOW;
    run_sum[ch] -= ring_mem[ch][pos];
    ring_mem[ch][pos] = smp;
    run_sum[ch] += smp;
    wr_pos[ch] = (pos + 1) % win;
    if (fill_cnt[ch] < win) begin
      fill_cnt[ch]++;
    end
    avg = (fill_cnt[ch] != 0) ? run_sum[ch] / fill_cnt[ch] : 0;
    if (avg > mma_pkg::AVG_MAX) begin
      avg = mma_pkg::AVG_MAX;
    end
    if (avg < -mma_pkg::AVG_MIN_MAG) begin
      avg = -mma_pkg::AVG_MIN_MAG;
    end
    return avg[mma_pkg::SAMPLE_W-1:0];
  endfunction

  task automatic send_sample(
    input logic        [mma_pkg::CH_W-1:0]     ch,
    input logic signed [mma_pkg::SAMPLE_W-1:0] smp
  );
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = gaps_on ? $urandom_range(1, 20) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid   <= 1'b1;
    in_channel <= ch;
    in_sample  <= smp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_averages.push_back(predict_average(ch, smp));
  endtask

  task automatic wait_for_averages();
    in_valid <= 1'b0;
    while (expected_averages.size() != 0) @(posedge clk);
  endtask

  // Writes every window, then one random register index past the last channel.
  task automatic program_windows(
    input logic [mma_pkg::WIN_W-1:0] win [mma_pkg::NUM_CHANNELS]
  );
    wait_for_averages();
    for (int i = 0; i < mma_pkg::NUM_CHANNELS; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= mma_pkg::CFG_IDX_W'(i);
      cfg_wdata <= win[i];
      @(posedge clk);
      win_cfg[i] = win[i];
    end
    cfg_index <= mma_pkg::CFG_IDX_W'($urandom_range(mma_pkg::NUM_CHANNELS,
                                                    2**mma_pkg::CFG_IDX_W - 1));
    cfg_wdata <= mma_pkg::WIN_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic test_reset_windows();
    send_sample(mma_pkg::CH_W'(0), 8'sd127);
    send_sample(mma_pkg::CH_W'(1), -8'sd128);
    send_sample(mma_pkg::CH_W'(2), -8'sd1);
    send_sample(mma_pkg::CH_W'(3), 8'sd1);
    send_sample(mma_pkg::CH_W'(4), 8'sd0);
    send_sample(mma_pkg::CH_W'(5), 8'sd127);
    send_sample(mma_pkg::CH_W'(6), -8'sd128);
    send_sample(mma_pkg::CH_W'(7), 8'sd127);
  endtask

  // Shrinking a long window leaves more ring entries in the sum than the fill
  // count, which pushes the quotient past the 8-bit range.
  task automatic test_average_saturation();
    program_windows('{7'd64, 7'd64, 7'd5, 7'd5, 7'd15, 7'd8});
    repeat (5) begin
      send_sample(mma_pkg::CH_W'(0), 8'sd127);
      send_sample(mma_pkg::CH_W'(1), -8'sd128);
    end
    program_windows('{7'd1, 7'd1, 7'd5, 7'd5, 7'd15, 7'd8});
    send_sample(mma_pkg::CH_W'(0), 8'sd127);
    send_sample(mma_pkg::CH_W'(1), -8'sd128);
  endtask

  task automatic test_window_limits();
    program_windows('{7'd0, 7'd127, 7'd65, 7'd64, 7'd1, 7'd2});
    send_sample(mma_pkg::CH_W'(0), -8'sd128);
    send_sample(mma_pkg::CH_W'(1), 8'sd85);
    send_sample(mma_pkg::CH_W'(2), -8'sd86);
    send_sample(mma_pkg::CH_W'(3), 8'sd127);
    send_sample(mma_pkg::CH_W'(4), -8'sd1);
    send_sample(mma_pkg::CH_W'(5), 8'sd64);
  endtask

  task automatic test_random_traffic();
    logic        [mma_pkg::WIN_W-1:0]    win [mma_pkg::NUM_CHANNELS];
    logic        [mma_pkg::CH_W-1:0]     ch;
    logic        [mma_pkg::CH_W-1:0]     focus;
    logic signed [mma_pkg::SAMPLE_W-1:0] smp;
    int                                  count;
    int                                  focus_pct;
    for (int ph = 0; ph < 9; ph++) begin
      for (int c = 0; c < mma_pkg::NUM_CHANNELS; c++) begin
        if (ph == 0) begin
          win[c] = mma_pkg::WIN_W'(mma_pkg::MAX_WINDOW);
        end else if (ph == 1) begin
          win[c] = mma_pkg::WIN_W'(1);
        end else if (ph == 2) begin
          win[c] = mma_pkg::WIN_W'(2**mma_pkg::WIN_W - 1);
        end else begin
          case ($urandom_range(0, 9))
            0:       win[c] = '0;
            1:       win[c] = mma_pkg::WIN_W'(mma_pkg::MAX_WINDOW);
            2:       win[c] = mma_pkg::WIN_W'($urandom_range(mma_pkg::MAX_WINDOW + 1,
                                                             2**mma_pkg::WIN_W - 1));
            3, 4, 5: win[c] = mma_pkg::WIN_W'($urandom_range(1, 4));
            default: win[c] = mma_pkg::WIN_W'($urandom_range(1, mma_pkg::MAX_WINDOW));
          endcase
        end
      end
      program_windows(win);
      gaps_on   = (ph % 3 != 1);
      focus     = mma_pkg::CH_W'($urandom_range(0, mma_pkg::NUM_CHANNELS - 1));
      focus_pct = (ph == 0) ? 90 : 50;
      count     = (ph == 0) ? 100 : 50;
      for (int n = 0; n < count; n++) begin
        if ($urandom_range(0, 15) == 0) begin
          ch = mma_pkg::CH_W'($urandom_range(mma_pkg::NUM_CHANNELS, 2**mma_pkg::CH_W - 1));
        end else if ($urandom_range(1, 100) <= focus_pct) begin
          ch = focus;
        end else begin
          ch = mma_pkg::CH_W'($urandom_range(0, mma_pkg::NUM_CHANNELS - 1));
        end
        case ($urandom_range(0, 9))
          0:       smp = 8'sd127;
          1:       smp = -8'sd128;
          default: smp = mma_pkg::SAMPLE_W'($urandom);
        endcase
        send_sample(ch, smp);
        if (ph == 4 && n == count / 2) begin
          wait_for_averages();
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rx_left == 0) begin
      if ($urandom_range(0, 4) == 0) begin
        out_ready <= 1'b1;
        rx_left   <= $urandom_range(30, 100);
      end else begin
        out_ready <= 1'($urandom_range(0, 1));
        rx_left   <= $urandom_range(0, 11);
      end
    end else begin
      rx_left <= rx_left - 1;
    end
  end

  always @(posedge clk) begin
    logic signed [mma_pkg::SAMPLE_W-1:0] want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_averages.size() == 0) begin
        log_failure($sformatf("unexpected average transaction: %0d", out_average));
      end else begin
        want = expected_averages.pop_front();
        if (out_average !== want) begin
          log_failure($sformatf("average mismatch: expected %0d, got %0d", want,
                                out_average));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_windows();
    test_average_saturation();
    test_window_limits();
    test_random_traffic();
    wait_for_averages();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
